### sv/sjs_pkg.sv
// ----------------------------------------------------------------------------
// sjs_pkg
// Shared types, fixed widths and constants of the scan jump segmentation block.
// ----------------------------------------------------------------------------
package sjs_pkg;

  localparam int SMP_W  = 16;
  localparam int XY_W   = 17;
  localparam int WD_W   = 18;
  localparam int OUT_DW = 56;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_START_ANGLE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_FAR_THR     = 2'd2;
  localparam logic [CFG_IW-1:0] REG_JUMP_THR    = 2'd3;

  // Angle before scaling, its scaled magnitude, and the reduction schedule.
  localparam int TH_W       = 31;
  localparam int UW         = TH_W + 10;
  localparam int WRAP_STEPS = 15;
  localparam int WK_W       = 4;

  localparam int ZW = 28;
  localparam int XW = 27;
  localparam int PW = 45;

  localparam int XY_SHIFT = 25;
  localparam int W_SHIFT  = 24;

  localparam logic signed [ZW-1:0] Q24_PI      = 28'sd52707179;
  localparam logic signed [ZW-1:0] Q24_TWO_PI  = 28'sd105414357;
  localparam logic signed [ZW-1:0] Q24_HALF_PI = 28'sd26353589;
  localparam logic [UW-1:0]        TWO_PI_U    = 41'd105414357;
  localparam logic signed [XW-1:0] Q24_GAIN    = 27'sd10188014;

  function automatic logic signed [ZW-1:0] arc_angle(input logic [4:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:  a = 28'sd13176795;
      5'd1:  a = 28'sd7778716;
      5'd2:  a = 28'sd4110060;
      5'd3:  a = 28'sd2086331;
      5'd4:  a = 28'sd1047214;
      5'd5:  a = 28'sd524117;
      5'd6:  a = 28'sd262123;
      5'd7:  a = 28'sd131069;
      5'd8:  a = 28'sd65536;
      5'd9:  a = 28'sd32768;
      5'd10: a = 28'sd16384;
      5'd11: a = 28'sd8192;
      5'd12: a = 28'sd4096;
      5'd13: a = 28'sd2048;
      5'd14: a = 28'sd1024;
      5'd15: a = 28'sd512;
      5'd16: a = 28'sd256;
      5'd17: a = 28'sd128;
      5'd18: a = 28'sd64;
      5'd19: a = 28'sd32;
      5'd20: a = 28'sd16;
      5'd21: a = 28'sd8;
      5'd22: a = 28'sd4;
      5'd23: a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_RDLO, OP_RDHI, OP_ANG, OP_WLOAD, OP_WSTEP, OP_WFIX,
    OP_FOLD, OP_CSTEP, OP_CFIN, OP_MULA, OP_RNDA, OP_MULB, OP_RNDB, OP_PACK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   job;
    logic   wphase;
  } dp_cmd_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
    logic wrap_done;
    logic cordic_done;
  } dp_stat_t;

endpackage

### sv/sjs_ctrl.sv
// ----------------------------------------------------------------------------
// sjs_ctrl
// Sequencer that walks each pending segment through store reads, angle
// reduction, CORDIC and the output multiplies, then hands the word out.
// ----------------------------------------------------------------------------
module sjs_ctrl
  import sjs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RDLO, S_RDHI, S_ANG, S_WLOAD, S_WSTEP, S_WFIX, S_FOLD,
    S_CSTEP, S_CFIN, S_MULA, S_RNDA, S_MULB, S_RNDB, S_PACK, S_OUT
  } state_t;

  state_t state_r;
  logic   job_r;
  logic   wphase_r;
  logic   in_tready_r;
  logic   out_tvalid_r;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      job_r        <= 1'b0;
      wphase_r     <= 1'b0;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready_r) begin
            in_tready_r <= 1'b0;
            state_r     <= S_DISP;
          end
        end
        S_DISP: begin
          wphase_r <= 1'b0;
          if (stat.a_valid) begin
            job_r   <= 1'b0;
            state_r <= S_RDLO;
          end else if (stat.b_valid) begin
            job_r   <= 1'b1;
            state_r <= S_RDLO;
          end else begin
            in_tready_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_RDLO:  state_r <= S_RDHI;
        S_RDHI:  state_r <= S_ANG;
        S_ANG:   state_r <= S_WLOAD;
        S_WLOAD: state_r <= S_WSTEP;
        S_WSTEP: begin
          if (stat.wrap_done) begin
            state_r <= S_WFIX;
          end
        end
        S_WFIX:  state_r <= S_FOLD;
        S_FOLD:  state_r <= S_CSTEP;
        S_CSTEP: begin
          if (stat.cordic_done) begin
            state_r <= S_CFIN;
          end
        end
        S_CFIN:  state_r <= S_MULA;
        S_MULA:  state_r <= S_RNDA;
        S_RNDA: begin
          if (wphase_r) begin
            state_r <= S_PACK;
          end else begin
            state_r <= S_MULB;
          end
        end
        S_MULB:  state_r <= S_RNDB;
        S_RNDB: begin
          // The centre is done; the same unit now works out the width angle.
          wphase_r <= 1'b1;
          state_r  <= S_ANG;
        end
        S_PACK: begin
          out_tvalid_r <= 1'b1;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            if (!job_r && stat.b_valid) begin
              job_r    <= 1'b1;
              wphase_r <= 1'b0;
              state_r  <= S_RDLO;
            end else begin
              in_tready_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        default: begin
          in_tready_r  <= 1'b1;
          out_tvalid_r <= 1'b0;
          state_r      <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.job    = job_r;
    cmd.wphase = wphase_r;
    case (state_r)
      S_IDLE:  cmd.op = (in_tvalid && in_tready_r) ? OP_ACCEPT : OP_NONE;
      S_RDLO:  cmd.op = OP_RDLO;
      S_RDHI:  cmd.op = OP_RDHI;
      S_ANG:   cmd.op = OP_ANG;
      S_WLOAD: cmd.op = OP_WLOAD;
      S_WSTEP: cmd.op = OP_WSTEP;
      S_WFIX:  cmd.op = OP_WFIX;
      S_FOLD:  cmd.op = OP_FOLD;
      S_CSTEP: cmd.op = OP_CSTEP;
      S_CFIN:  cmd.op = OP_CFIN;
      S_MULA:  cmd.op = OP_MULA;
      S_RNDA:  cmd.op = OP_RNDA;
      S_MULB:  cmd.op = OP_MULB;
      S_RNDB:  cmd.op = OP_RNDB;
      S_PACK:  cmd.op = OP_PACK;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

### sv/sjs_dp.sv
// ----------------------------------------------------------------------------
// sjs_dp
// Datapath: configuration, segment tracking, sample store, angle reduction,
// iterative CORDIC, shared multiplier and the output word.
// ----------------------------------------------------------------------------
module sjs_dp
  import sjs_pkg::*;
#(
  parameter int SCAN_LEN     = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [SMP_W-1:0]  in_range,
  input  logic              in_scan_end,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output logic [OUT_DW-1:0] out_data,
  output logic              out_last
);

  localparam int IW = $clog2(SCAN_LEN);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(CORDIC_STEPS);

  localparam logic signed [PW-1:0] XY_HALF = PW'(1) << (XY_SHIFT - 1);
  localparam logic signed [PW-1:0] W_HALF  = PW'(1) << (W_SHIFT - 1);
  localparam logic signed [PW-1:0] XY_LIM  = PW'(65535);
  localparam logic signed [PW-1:0] W_LIM   = PW'(131070);

  function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [PW-1:0] q);
    logic signed [PW-1:0] v;
    v = q;
    if (q > XY_LIM) begin
      v = XY_LIM;
    end else if (q < -XY_LIM) begin
      v = -XY_LIM;
    end
    return v[XY_W-1:0];
  endfunction

  function automatic logic signed [WD_W-1:0] sat_w(input logic signed [PW-1:0] q);
    logic signed [PW-1:0] v;
    v = q;
    if (q > W_LIM) begin
      v = W_LIM;
    end else if (q < -W_LIM) begin
      v = -W_LIM;
    end
    return v[WD_W-1:0];
  endfunction

  // Configuration registers.
  logic signed [15:0] start_r;
  logic signed [12:0] step_r;
  logic [15:0]        far_r;
  logic [15:0]        jth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= -16'sd25736;
      step_r  <= 13'sd26;
      far_r   <= '0;
      jth_r   <= 16'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_ANGLE: start_r <= cfg_wdata;
        REG_ANGLE_STEP:  step_r  <= cfg_wdata[12:0];
        REG_FAR_THR:     far_r   <= cfg_wdata;
        REG_JUMP_THR:    jth_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Segment tracking.
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    seg_start_r;
  logic [LW-1:0]    seg_len_r;
  logic [SMP_W-1:0] prev_r;
  logic [SMP_W-1:0] seg_first_r;
  logic             in_region_r;
  logic             multi_r;
  logic             a_valid_r;
  logic             b_valid_r;

  // Up to two segments close on one word: the one before a jump or separator,
  // and the one still open when the scan ends.
  logic [IW-1:0]    job_s_r [2];
  logic [LW-1:0]    job_n_r [2];
  logic [SMP_W-1:0] job_f_r [2];
  logic [SMP_W-1:0] job_l_r [2];

  logic             acc;
  logic             sep;
  logic             last;
  logic [SMP_W-1:0] diff;
  logic             jump;
  logic             restart;
  logic [IW-1:0]    new_start;
  logic [LW-1:0]    new_len;
  logic [SMP_W-1:0] new_first;

  assign acc       = (cmd.op == OP_ACCEPT);
  assign sep       = (in_range < far_r);
  assign last      = in_scan_end || (idx_r == IW'(SCAN_LEN - 1));
  assign diff      = (in_range > prev_r) ? (in_range - prev_r) : (prev_r - in_range);
  assign jump      = (diff >= jth_r);
  assign restart   = !in_region_r || jump;
  assign new_start = restart ? idx_r : seg_start_r;
  assign new_len   = restart ? LW'(1) : (seg_len_r + LW'(1));
  assign new_first = restart ? in_range : seg_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      seg_start_r <= '0;
      seg_len_r   <= '0;
      prev_r      <= '0;
      seg_first_r <= '0;
      in_region_r <= 1'b0;
      multi_r     <= 1'b0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
    end else if (acc) begin
      idx_r <= last ? '0 : (idx_r + IW'(1));
      if (sep) begin
        a_valid_r   <= in_region_r && multi_r;
        b_valid_r   <= 1'b0;
        in_region_r <= 1'b0;
      end else begin
        a_valid_r   <= in_region_r && jump;
        b_valid_r   <= last && in_region_r;
        seg_start_r <= new_start;
        seg_len_r   <= new_len;
        seg_first_r <= new_first;
        prev_r      <= in_range;
        multi_r     <= in_region_r;
        in_region_r <= !last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      job_s_r[0] <= seg_start_r;
      job_n_r[0] <= seg_len_r;
      job_f_r[0] <= seg_first_r;
      job_l_r[0] <= prev_r;
      job_s_r[1] <= new_start;
      job_n_r[1] <= new_len;
      job_f_r[1] <= new_first;
      job_l_r[1] <= in_range;
    end
  end

  // Sample store, one write and one registered read port.
  logic [SMP_W-1:0] store_mem [SCAN_LEN];
  logic [SMP_W-1:0] rd_data_r;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    js;
  logic [LW-1:0]    jn;
  logic [IW-1:0]    hi_addr;
  logic [IW-1:0]    lo_addr;

  assign js      = job_s_r[cmd.job];
  assign jn      = job_n_r[cmd.job];
  assign hi_addr = js + jn[LW-1:1];
  // An odd length reads the middle sample twice, so the sum is twice it.
  assign lo_addr = jn[0] ? hi_addr : (hi_addr - IW'(1));
  assign rd_addr = (cmd.op == OP_RDLO) ? lo_addr : hi_addr;

  always_ff @(posedge clk) begin
    if (acc && !sep) begin
      store_mem[idx_r] <= in_range;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // Angle formation.
  logic [SMP_W-1:0]       lo_r;
  logic [SMP_W:0]         m2_r;
  logic [SMP_W:0]         sum_c;
  logic [IW+1:0]          c_term;
  logic [LW-1:0]          w_term;
  logic signed [IW+15:0]  prod_c;
  logic signed [IW+14:0]  prod_w;
  logic signed [TH_W-1:0] th_r;
  logic signed [TH_W-1:0] th_abs;

  assign sum_c  = {1'b0, job_f_r[cmd.job]} + {1'b0, job_l_r[cmd.job]};
  assign c_term = {1'b0, js, 1'b0} + (IW+2)'(jn) - (IW+2)'(1);
  assign w_term = jn - LW'(1);
  assign prod_c = $signed({1'b0, c_term}) * step_r;
  assign prod_w = $signed({1'b0, w_term}) * step_r;
  assign th_abs = th_r[TH_W-1] ? -th_r : th_r;

  // Reduction and CORDIC registers.
  logic [UW-1:0]        u_r;
  logic                 neg_r;
  logic [WK_W-1:0]      wk_r;
  logic [UW-1:0]        wsub;
  logic signed [ZW-1:0] m_s;
  logic signed [ZW-1:0] r1;
  logic signed [ZW-1:0] z_r;
  logic                 flip_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic [CW-1:0]        ci_r;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] arc;
  logic signed [XW-1:0] cos_r;
  logic signed [XW-1:0] sin_r;

  assign wsub = TWO_PI_U << wk_r;
  assign m_s  = $signed({1'b0, u_r[ZW-2:0]});
  assign r1   = (neg_r && (m_s != '0)) ? (Q24_TWO_PI - m_s) : m_s;
  assign dx   = y_r >>> ci_r;
  assign dy   = x_r >>> ci_r;
  assign arc  = arc_angle(5'(ci_r));

  // Multiply and round.
  logic signed [PW-1:0]   p_r;
  logic signed [PW-1:0]   q_xy_sum;
  logic signed [PW-1:0]   q_w_sum;
  logic signed [PW-1:0]   q_xy;
  logic signed [PW-1:0]   q_w;
  logic signed [XY_W-1:0] x_res_r;
  logic signed [XY_W-1:0] y_res_r;
  logic signed [WD_W-1:0] w_res_r;
  logic [OUT_DW-1:0]      out_data_r;
  logic                   out_last_r;

  assign q_xy_sum = p_r + XY_HALF;
  assign q_w_sum  = p_r + W_HALF;
  assign q_xy     = q_xy_sum >>> XY_SHIFT;
  assign q_w      = q_w_sum >>> W_SHIFT;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RDHI: lo_r <= rd_data_r;
      OP_ANG: begin
        if (cmd.wphase) begin
          th_r <= TH_W'(prod_w);
        end else begin
          th_r <= TH_W'(start_r) + TH_W'(start_r) + TH_W'(prod_c);
          m2_r <= {1'b0, lo_r} + {1'b0, rd_data_r};
        end
      end
      OP_WLOAD: begin
        u_r   <= {th_abs, 10'b0};
        neg_r <= th_r[TH_W-1];
        wk_r  <= WK_W'(WRAP_STEPS - 1);
      end
      OP_WSTEP: begin
        if (u_r >= wsub) begin
          u_r <= u_r - wsub;
        end
        wk_r <= wk_r - WK_W'(1);
      end
      OP_WFIX: z_r <= (r1 >= Q24_PI) ? (r1 - Q24_TWO_PI) : r1;
      OP_FOLD: begin
        if (z_r > Q24_HALF_PI) begin
          z_r    <= z_r - Q24_PI;
          flip_r <= 1'b1;
        end else if (z_r < -Q24_HALF_PI) begin
          z_r    <= z_r + Q24_PI;
          flip_r <= 1'b1;
        end else begin
          flip_r <= 1'b0;
        end
        x_r  <= Q24_GAIN;
        y_r  <= '0;
        ci_r <= '0;
      end
      OP_CSTEP: begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - arc;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + arc;
        end
        ci_r <= ci_r + CW'(1);
      end
      OP_CFIN: begin
        cos_r <= flip_r ? -x_r : x_r;
        sin_r <= flip_r ? -y_r : y_r;
      end
      OP_MULA: begin
        if (cmd.wphase) begin
          p_r <= $signed({1'b0, sum_c}) * sin_r;
        end else begin
          p_r <= $signed({1'b0, m2_r}) * cos_r;
        end
      end
      OP_MULB: p_r <= $signed({1'b0, m2_r}) * sin_r;
      OP_RNDA: begin
        if (cmd.wphase) begin
          w_res_r <= sat_w(q_w);
        end else begin
          x_res_r <= sat_xy(q_xy);
        end
      end
      OP_RNDB: y_res_r <= sat_xy(q_xy);
      OP_PACK: begin
        out_data_r <= {(OUT_DW - WD_W - 2*XY_W)'(0), w_res_r, y_res_r, x_res_r};
        out_last_r <= cmd.job || !b_valid_r;
      end
      default: ;
    endcase
  end

  assign stat.a_valid     = a_valid_r;
  assign stat.b_valid     = b_valid_r;
  assign stat.wrap_done   = (wk_r == '0);
  assign stat.cordic_done = (ci_r == CW'(CORDIC_STEPS - 1));

  assign out_data = out_data_r;
  assign out_last = out_last_r;

endmodule

### sv/scan_jump_segment_obstacles.sv
// ----------------------------------------------------------------------------
// scan_jump_segment_obstacles
// Splits a lidar scan into obstacle segments and reports centre and width.
// ----------------------------------------------------------------------------
// One range word is taken at a time. A word that closes no segment goes
// through the dispatch state and straight back to idle. Each obstacle result
// is offered once the fifteen-step angle reduction and the CORDIC iterations
// have run, each once for the centre angle and once for the width angle on
// one shared unit, and three multiplies have gone through one multiplier; a
// word that closes two segments runs all of this for each segment. in_tready
// stays low from the accepted word until its last result has been taken. The
// sample store holds SCAN_LEN words and needs no clearing after reset.
module scan_jump_segment_obstacles
  import sjs_pkg::*;
#(
  parameter int SCAN_LEN     = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] range_sample
  input  logic              in_tlast,   // scan_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [16:0] centre_x, [33:17] centre_y,
                                        // [51:34] obstacle_width, [55:52] zero
  output logic              out_tlast,  // last_of_run
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sjs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sjs_dp #(
    .SCAN_LEN     (SCAN_LEN),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_range    (in_tdata),
    .in_scan_end (in_tlast),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_data    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

### sv/sjs_check.sv
// ----------------------------------------------------------------------------
// sjs_check
// Port-level checks of the segmentation block, bound to the top level.
// ----------------------------------------------------------------------------
module sjs_check
  import sjs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tlast
);

  // The block works on one word at a time, so it never offers a result
  // while it is open for input.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is offered");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready stayed high after an accepted word");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed or dropped");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind scan_jump_segment_obstacles sjs_check u_sjs_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scan_jump_segment_obstacles: scans with random
// regions and jumps are streamed in, obstacle words are predicted in the bench
// and compared field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb;
  import sjs_pkg::*;

  localparam int SCAN_LEN = 1024;
  localparam int CORDIC_STEPS = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic signed [17:0] wd;
    logic               last;
  } obstacle_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  scan_jump_segment_obstacles #(.SCAN_LEN(SCAN_LEN), .CORDIC_STEPS(CORDIC_STEPS)) dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  longint p_start, p_step, p_far, p_jump;
  logic [15:0] p_store [SCAN_LEN];
  int unsigned p_idx, p_seg_start, p_seg_len;
  longint p_prev, p_first;
  bit p_in_region, p_multi;

  obstacle_t pending_obstacles[$];
  int errors = 0;
  longint cycles = 0;
  int sample_pos = 0;  // position in current scan, bench-side

  function automatic longint fshift(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint wrap_q24(longint t);
    longint r;
    r = t % 105414357;
    if (r < 0) r += 105414357;
    if (r >= 52707179) r -= 105414357;
    return r;
  endfunction

  function automatic longint arc_of(int i);
    longint tbl [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
      262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  task automatic sincos(input longint ang, output longint c, output longint s);
    bit flip;
    longint x, y, z, dx, dy;
    flip = 0; x = 10188014; y = 0; z = ang;
    if (z > 26353589) begin
      z -= 52707179; flip = 1;
    end else if (z < -26353589) begin
      z += 52707179; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = fshift(y, i); dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_of(i);
      end else begin
        x += dx; y -= dy; z += arc_of(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint sat(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  task automatic predict_segment();
    longint n, m2, th, c, s;
    int unsigned half;
    obstacle_t o;
    n = p_seg_len;
    half = p_seg_len / 2;
    if (p_seg_len % 2) m2 = 2 * longint'(p_store[p_seg_start + half]);
    else m2 = longint'(p_store[p_seg_start + half - 1]) + longint'(p_store[p_seg_start + half]);
    th = 2 * p_start + (2 * longint'(p_seg_start) + n - 1) * p_step;
    sincos(wrap_q24(th * 1024), c, s);
    o.cx = 17'(sat(fshift(m2 * c + (64'sd1 << 24), 25), 65535));
    o.cy = 17'(sat(fshift(m2 * s + (64'sd1 << 24), 25), 65535));
    sincos(wrap_q24((n - 1) * p_step * 1024), c, s);
    o.wd = 18'(sat(fshift((p_first + p_prev) * s + (64'sd1 << 23), 24), 131070));
    o.last = 0;
    pending_obstacles = {pending_obstacles, o};
  endtask

  task automatic predict_sample(input logic [15:0] smp, input bit scan_end);
    bit last;
    int n_queued;
    longint diff;
    n_queued = pending_obstacles.size();
    last = scan_end || p_idx >= SCAN_LEN - 1;
    if (smp < p_far) begin
      if (p_in_region && p_multi) predict_segment();
      p_in_region = 0;
    end else begin
      p_store[p_idx] = smp;
      if (!p_in_region) begin
        p_in_region = 1; p_multi = 0;
        p_seg_start = p_idx; p_seg_len = 1; p_first = smp;
      end else begin
        diff = smp > p_prev ? smp - p_prev : p_prev - smp;
        p_multi = 1;
        if (diff >= p_jump) begin
          predict_segment();
          p_seg_start = p_idx; p_seg_len = 1; p_first = smp;
        end else begin
          p_seg_len++;
        end
      end
      p_prev = smp;
      if (last) begin
        if (p_multi) predict_segment();
        p_in_region = 0;
      end
    end
    if (last) begin
      p_idx = 0; p_in_region = 0;
    end else begin
      p_idx++;
    end
    if (pending_obstacles.size() > n_queued)
      pending_obstacles[pending_obstacles.size() - 1].last = 1;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // Valid stays up after an accepted word; the next gap, drain or word moves it.
  task automatic send_sample(input logic [15:0] smp, input bit scan_end);
    int n_gap;
    n_gap = gap_len();
    if (n_gap > 0) begin
      in_tvalid <= 0;
      repeat (n_gap) @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= smp; in_tlast <= scan_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(smp, scan_end);
    sample_pos = (scan_end || sample_pos >= SCAN_LEN - 1) ? 0 : sample_pos + 1;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_obstacles.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_START_ANGLE: p_start = longint'(signed'(val));
      REG_ANGLE_STEP:  p_step = longint'(signed'(val[12:0]));
      REG_FAR_THR:     p_far = val;
      default:         p_jump = val;
    endcase
  endtask

  task automatic set_config(input int sa, input int st, input int far, input int jmp);
    drain();
    write_reg(REG_START_ANGLE, 16'(sa));
    write_reg(REG_ANGLE_STEP, 16'(st));
    write_reg(REG_FAR_THR, 16'(far));
    write_reg(REG_JUMP_THR, 16'(jmp));
    cfg_we <= 0;
  endtask

  // Closes the current scan so the next phase starts at index zero.
  task automatic finish_scan();
    send_sample(16'h0000, 1);
  endtask

  task automatic test_directed();
    set_config(-25736, 2048, 256, 128);
    send_sample(16'hFFFF, 0);           // lone sample region, dropped
    send_sample(16'h0000, 0);
    send_sample(16'hFFFF, 0);
    send_sample(16'hFFF0, 0);
    send_sample(16'h0100, 0);           // jump
    send_sample(16'h0110, 0);
    send_sample(16'h0010, 0);           // separator closes region
    send_sample(16'h8000, 0);
    send_sample(16'h8005, 0);
    send_sample(16'h1000, 1);           // jump on the scan end, two results
    set_config(25736, -2048, 0, 0);     // zero jump: every sample its own segment
    send_sample(16'h0000, 0);
    send_sample(16'hFFFF, 0);
    send_sample(16'hFFFF, 0);
    send_sample(16'h5555, 0);
    send_sample(16'hAAAA, 1);
    set_config(0, 1, 0, 65535);
    send_sample(16'h0200, 0);
    send_sample(16'h0300, 0);
    send_sample(16'h0400, 1);
  endtask

  task automatic test_random_scans(input int count);
    int sent, run;
    logic [15:0] base, smp;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();  // sender holds off until every result is in
        case ($urandom_range(0, 2))
          0: set_config($urandom_range(0, 51472) - 25736, $urandom_range(0, 4096) - 2048,
                        $urandom_range(0, 3000), $urandom_range(0, 2000));
          1: set_config(-25736, -2048, 65535, 65535);
          default: set_config(25736, 2048, 0, $urandom_range(0, 1));
        endcase
      end
      run = $urandom_range(1, 12);
      base = 16'($urandom_range(p_far, 65535));
      for (int i = 0; i < run; i++) begin
        if ($urandom_range(0, 9) == 0) base = 16'($urandom);
        smp = base + 16'($urandom_range(0, 255)) - 16'd128;
        if ($urandom_range(0, 15) == 0) smp = 16'($urandom);
        send_sample(smp, $urandom_range(0, 30) == 0);
        sent++;
      end
      if (p_far > 0) send_sample(16'($urandom_range(0, p_far - 1)), $urandom_range(0, 5) == 0);
      else send_sample(16'($urandom), 1);
      sent++;
    end
    if (sample_pos != 0) finish_scan();
  endtask

  // Result checker with random receiver stalls.
  always @(posedge clk) begin
    obstacle_t exp_o;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_obstacles.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", out_tdata);
        end else begin
          exp_o = pending_obstacles.pop_front();
          if (out_tdata[16:0] !== exp_o.cx || out_tdata[33:17] !== exp_o.cy ||
              out_tdata[51:34] !== exp_o.wd || out_tdata[55:52] !== 4'd0 ||
              out_tlast !== exp_o.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp x=%0d y=%0d w=%0d l=%0d got x=%0d y=%0d w=%0d l=%0d",
                       exp_o.cx, exp_o.cy, exp_o.wd, exp_o.last,
                       $signed(out_tdata[16:0]), $signed(out_tdata[33:17]),
                       $signed(out_tdata[51:34]), out_tlast);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 50 && cycles[12]);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[scan_jump_segment_obstacles] ERROR");
      $finish;
    end
  end

  initial begin
    p_start = -25736; p_step = 26; p_far = 0; p_jump = 128;
    p_idx = 0; p_seg_start = 0; p_seg_len = 0; p_prev = 0; p_first = 0;
    p_in_region = 0; p_multi = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random_scans(880);
    drain();
    if (errors == 0) begin
      $display("[scan_jump_segment_obstacles] OK");
    end else begin
      $display("[scan_jump_segment_obstacles] ERROR");
    end
    $finish;
  end
endmodule
